### src/msrf_pkg.sv
package msrf_pkg;

    // Bank sizes (upper limits for the top-level parameters)
    localparam int FIXED_RANGE_MAX    = 32;
    localparam int VARIABLE_RANGE_MAX = 16;

    localparam int IDX_W  = 32;
    localparam int HALF_W = 32;
    localparam int WORD_W = 64;

    // Register map
    localparam logic [IDX_W-1:0] IDX_INTC_BASE = 32'h0000_001B;
    localparam logic [IDX_W-1:0] IDX_FIXED_BASE = 32'h0000_0250;
    localparam logic [IDX_W-1:0] IDX_VAR_BASE  = 32'h0000_0200;
    localparam logic [IDX_W-1:0] IDX_PAGE_ATTR = 32'h0000_0277;
    localparam logic [IDX_W-1:0] IDX_DEF_TYPE  = 32'h0000_02FF;
    localparam logic [IDX_W-1:0] IDX_FAST_BASE = 32'h0000_0174;
    localparam logic [IDX_W-1:0] IDX_CONST     = 32'h0000_00FE;
    localparam logic [IDX_W-1:0] IDX_STAMP     = 32'h0000_0010;
    localparam logic [IDX_W-1:0] IDX_EXT_FEAT  = 32'hC000_0080;

    localparam logic [WORD_W-1:0] CONST_VALUE = 64'h0000_0000_0000_0508;

    // Fast-call registers: three 32-bit entries
    localparam int FAST_COUNT = 3;
    localparam int FAST_IW    = $clog2(FAST_COUNT);

    // Access kind
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Result status
    typedef logic [1:0] msrf_status_t;
    localparam msrf_status_t ST_DONE    = 2'd0;
    localparam msrf_status_t ST_FAULT   = 2'd1;
    localparam msrf_status_t ST_UNKNOWN = 2'd2;

    // Index decode result, one flag per register group
    typedef struct packed {
        logic intc_base;
        logic page_attr;
        logic def_type;
        logic ext_feat;
        logic fixed;
        logic variable;
        logic fast;
        logic stamp;
        logic const_ro;
    } msrf_hit_t;

endpackage

### src/msrf_decode.sv
module msrf_decode
    import msrf_pkg::*;
#(
    parameter int FIXED_RANGE_COUNT    = FIXED_RANGE_MAX,
    parameter int VARIABLE_RANGE_COUNT = VARIABLE_RANGE_MAX,
    localparam int FIX_IW = (FIXED_RANGE_COUNT > 1) ? $clog2(FIXED_RANGE_COUNT) : 1,
    localparam int VAR_IW = (VARIABLE_RANGE_COUNT > 1) ? $clog2(VARIABLE_RANGE_COUNT) : 1
)
(
    input  logic [IDX_W-1:0]   reg_index,
    output msrf_hit_t          hit,
    output logic [FIX_IW-1:0]  fixed_sel,
    output logic [VAR_IW-1:0]  var_sel,
    output logic [FAST_IW-1:0] fast_sel
);

    logic [IDX_W-1:0] fixed_diff;
    logic [IDX_W-1:0] var_diff;
    logic [IDX_W-1:0] fast_diff;

    assign fixed_diff = reg_index - IDX_FIXED_BASE;
    assign var_diff   = reg_index - IDX_VAR_BASE;
    assign fast_diff  = reg_index - IDX_FAST_BASE;

    always_comb
    begin
        hit.intc_base = (reg_index == IDX_INTC_BASE);
        hit.page_attr = (reg_index == IDX_PAGE_ATTR);
        hit.def_type  = (reg_index == IDX_DEF_TYPE);
        hit.ext_feat  = (reg_index == IDX_EXT_FEAT);
        hit.fixed     = (reg_index >= IDX_FIXED_BASE) &&
                        (fixed_diff < IDX_W'(FIXED_RANGE_COUNT));
        hit.variable  = (reg_index >= IDX_VAR_BASE) &&
                        (var_diff < IDX_W'(VARIABLE_RANGE_COUNT));
        hit.fast      = (reg_index >= IDX_FAST_BASE) &&
                        (fast_diff < IDX_W'(FAST_COUNT));
        hit.stamp     = (reg_index == IDX_STAMP);
        hit.const_ro  = (reg_index == IDX_CONST);
    end

    assign fixed_sel = fixed_diff[FIX_IW-1:0];
    assign var_sel   = var_diff[VAR_IW-1:0];
    assign fast_sel  = fast_diff[FAST_IW-1:0];

endmodule

### src/msrf_regs.sv
module msrf_regs
    import msrf_pkg::*;
#(
    parameter int FIXED_RANGE_COUNT    = FIXED_RANGE_MAX,
    parameter int VARIABLE_RANGE_COUNT = VARIABLE_RANGE_MAX,
    localparam int FIX_IW = (FIXED_RANGE_COUNT > 1) ? $clog2(FIXED_RANGE_COUNT) : 1,
    localparam int VAR_IW = (VARIABLE_RANGE_COUNT > 1) ? $clog2(VARIABLE_RANGE_COUNT) : 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               commit,       // access leaves the decode stage
    input  logic               func,
    input  msrf_hit_t          hit,
    input  logic [FIX_IW-1:0]  fixed_sel,
    input  logic [VAR_IW-1:0]  var_sel,
    input  logic [FAST_IW-1:0] fast_sel,
    input  logic [WORD_W-1:0]  wdata,
    input  logic [WORD_W-1:0]  cycle_now,
    input  logic               apic_present,
    output logic [WORD_W-1:0]  rvalue,
    output msrf_status_t       status
);

    logic [WORD_W-1:0] intc_base_reg;
    logic [WORD_W-1:0] page_attr_reg;
    logic [WORD_W-1:0] def_type_reg;
    logic [WORD_W-1:0] ext_feat_reg;
    logic [WORD_W-1:0] stamp_offset_reg;
    logic [WORD_W-1:0] fixed_reg [FIXED_RANGE_COUNT];
    logic [WORD_W-1:0] var_reg   [VARIABLE_RANGE_COUNT];
    logic [HALF_W-1:0] fast_reg  [FAST_COUNT];

    logic              is_wide;
    logic              wr;
    logic [WORD_W-1:0] wide_value;
    logic [WORD_W-1:0] fast_value;

    assign is_wide = hit.intc_base | hit.page_attr | hit.def_type | hit.ext_feat |
                     hit.fixed | hit.variable;
    assign wr      = commit && (func == FUNC_WRITE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            intc_base_reg    <= '0;
            page_attr_reg    <= '0;
            def_type_reg     <= '0;
            ext_feat_reg     <= '0;
            stamp_offset_reg <= '0;
            for (int i = 0; i < FIXED_RANGE_COUNT; i++)
            begin
                fixed_reg[i] <= '0;
            end
            for (int i = 0; i < VARIABLE_RANGE_COUNT; i++)
            begin
                var_reg[i] <= '0;
            end
            for (int i = 0; i < FAST_COUNT; i++)
            begin
                fast_reg[i] <= '0;
            end
        end
        else if (wr)
        begin
            if (hit.intc_base)
            begin
                intc_base_reg <= wdata;
            end
            if (hit.page_attr)
            begin
                page_attr_reg <= wdata;
            end
            if (hit.def_type)
            begin
                def_type_reg <= wdata;
            end
            if (hit.ext_feat)
            begin
                ext_feat_reg <= wdata;
            end
            if (hit.fixed)
            begin
                fixed_reg[fixed_sel] <= wdata;
            end
            if (hit.variable)
            begin
                var_reg[var_sel] <= wdata;
            end
            if (hit.fast)
            begin
                fast_reg[fast_sel] <= wdata[HALF_W-1:0];
            end
            if (hit.stamp)
            begin
                stamp_offset_reg <= cycle_now - wdata;
            end
        end
    end

    // Stored 64-bit registers: groups are disjoint, so a one-hot select
    always_comb
    begin
        wide_value = '0;
        if (hit.intc_base)
        begin
            wide_value = intc_base_reg;
        end
        else if (hit.page_attr)
        begin
            wide_value = page_attr_reg;
        end
        else if (hit.def_type)
        begin
            wide_value = def_type_reg;
        end
        else if (hit.ext_feat)
        begin
            wide_value = ext_feat_reg;
        end
        else if (hit.fixed)
        begin
            wide_value = fixed_reg[fixed_sel];
        end
        else if (hit.variable)
        begin
            wide_value = var_reg[var_sel];
        end
    end

    always_comb
    begin
        fast_value = '0;
        for (int i = 0; i < FAST_COUNT; i++)
        begin
            if (fast_sel == FAST_IW'(i))
            begin
                fast_value = {{(WORD_W-HALF_W){1'b0}}, fast_reg[i]};
            end
        end
    end

    always_comb
    begin
        rvalue = '0;
        status = ST_DONE;
        if (func == FUNC_WRITE)
        begin
            if (!(is_wide || hit.fast || hit.stamp))
            begin
                status = ST_UNKNOWN;
            end
        end
        else if (hit.intc_base && !apic_present)
        begin
            status = ST_FAULT;
        end
        else if (is_wide)
        begin
            rvalue = wide_value;
        end
        else if (hit.fast)
        begin
            rvalue = fast_value;
        end
        else if (hit.stamp)
        begin
            rvalue = cycle_now - stamp_offset_reg;
        end
        else if (hit.const_ro)
        begin
            rvalue = CONST_VALUE;
        end
        else
        begin
            status = ST_UNKNOWN;
        end
    end

endmodule

### src/model_specific_register_file_core.sv
// A transaction passes through an input register and then a result register.
// Throughput: one transaction per cycle; the decode stage advances whenever the
// result register is empty or being taken, so stalls propagate back to s_tready.
// Reset (rst_n, async, active low): all stored registers and bank entries clear to zero,
// the time-stamp offset clears to zero, apic_present resets to 1, pipeline empties.
module model_specific_register_file_core
    import msrf_pkg::*;
#(
    parameter int FIXED_RANGE_COUNT    = FIXED_RANGE_MAX,
    parameter int VARIABLE_RANGE_COUNT = VARIABLE_RANGE_MAX
)
(
    input  logic         clk,
    input  logic         rst_n,

    // Configuration: apic_present
    input  logic         cfg_we,
    input  logic         cfg_wdata,

    // Access stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,   // reg_index[31:0], data_high[63:32],
                                    // data_low[95:64], cycle_now[159:96]
    input  logic         s_tuser,   // func (0 read, 1 write)

    // Result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // read_high[31:0], read_low[63:32]
    output logic [1:0]   m_tuser    // status
);

    localparam int FIX_IW = (FIXED_RANGE_COUNT > 1) ? $clog2(FIXED_RANGE_COUNT) : 1;
    localparam int VAR_IW = (VARIABLE_RANGE_COUNT > 1) ? $clog2(VARIABLE_RANGE_COUNT) : 1;

    // Config register
    logic apic_present_reg;

    // Input stage
    logic              in_valid_reg;
    logic              in_func_reg;
    logic [IDX_W-1:0]  in_index_reg;
    logic [WORD_W-1:0] in_data_reg;
    logic [WORD_W-1:0] in_now_reg;

    // Result stage
    logic              out_valid_reg;
    logic [WORD_W-1:0] out_value_reg;
    msrf_status_t      out_status_reg;

    logic              out_ready;
    logic              in_ready;
    logic              commit;

    msrf_hit_t          hit;
    logic [FIX_IW-1:0]  fixed_sel;
    logic [VAR_IW-1:0]  var_sel;
    logic [FAST_IW-1:0] fast_sel;
    logic [WORD_W-1:0]  rvalue_next;
    msrf_status_t       status_next;

    // Handshake chain: result register frees up when empty or taken this cycle
    assign out_ready = !out_valid_reg || m_tready;
    assign commit    = in_valid_reg && out_ready;
    assign in_ready  = !in_valid_reg || out_ready;
    assign s_tready  = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            apic_present_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            apic_present_reg <= cfg_wdata;
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_ready)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload: captured on transaction, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_tvalid && in_ready)
        begin
            in_func_reg  <= s_tuser;
            in_index_reg <= s_tdata[31:0];
            in_data_reg  <= {s_tdata[63:32], s_tdata[95:64]};
            in_now_reg   <= s_tdata[159:96];
        end
        if (commit)
        begin
            out_value_reg  <= rvalue_next;
            out_status_reg <= status_next;
        end
    end

    msrf_decode #(
        .FIXED_RANGE_COUNT    (FIXED_RANGE_COUNT),
        .VARIABLE_RANGE_COUNT (VARIABLE_RANGE_COUNT)
    ) u_decode (
        .reg_index (in_index_reg),
        .hit       (hit),
        .fixed_sel (fixed_sel),
        .var_sel   (var_sel),
        .fast_sel  (fast_sel)
    );

    // Register storage; writes land on commit so the next access sees them
    msrf_regs #(
        .FIXED_RANGE_COUNT    (FIXED_RANGE_COUNT),
        .VARIABLE_RANGE_COUNT (VARIABLE_RANGE_COUNT)
    ) u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .commit       (commit),
        .func         (in_func_reg),
        .hit          (hit),
        .fixed_sel    (fixed_sel),
        .var_sel      (var_sel),
        .fast_sel     (fast_sel),
        .wdata        (in_data_reg),
        .cycle_now    (in_now_reg),
        .apic_present (apic_present_reg),
        .rvalue       (rvalue_next),
        .status       (status_next)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_value_reg[HALF_W-1:0], out_value_reg[WORD_W-1:HALF_W]};
    assign m_tuser  = out_status_reg;

endmodule
